[hdl/brfo_pkg.sv]
package brfo_pkg;

	// Field widths fixed by the interface
	localparam int LEN_W    = 7;
	localparam int BYTE_W   = 8;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	// Capacity register value after reset
	localparam logic [LEN_W-1:0] CAP_RESET = 7'd64;

	// Register index, taken from paddr[2]
	localparam logic REG_OW  = 1'b0;
	localparam logic REG_CAP = 1'b1;

	// Request codes
	localparam logic REQ_ENQ = 1'b0;
	localparam logic REQ_DEQ = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_TOO_LONG = 2'd1,
		ST_NO_SPACE = 2'd2,
		ST_NO_DATA  = 2'd3
	} status_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_DEQ  = 1'b1
	} fsm_t;

	// Settings handed from the register block to the datapath
	typedef struct packed {
		logic             ow_en;
		logic [LEN_W-1:0] ring_size;
		logic             flush;
	} cfg_t;

endpackage

[hdl/brfo_ram.sv]
module brfo_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// read data holds until the next read
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/brfo_cfg.sv]
module brfo_cfg
	import brfo_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic             ow_q;
	logic [LEN_W-1:0] cap_q;
	logic             wr_en;
	logic             cap_wr;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cap_wr = wr_en && (paddr[2] == REG_CAP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ow_q  <= 1'b0;
			cap_q <= CAP_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_OW:  ow_q  <= pwdata[0];
				REG_CAP: cap_q <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_OW:  prdata = DATA_W'(ow_q);
			REG_CAP: prdata = DATA_W'(cap_q);
			default: prdata = '0;
		endcase
	end

	// zero acts as one, anything past the store acts as the full store
	always_comb begin
		cfg.ow_en = ow_q;
		cfg.flush = cap_wr;
		if (cap_q == '0) begin
			cfg.ring_size = LEN_W'(1);
		end else if (cap_q > LEN_W'(DEPTH)) begin
			cfg.ring_size = LEN_W'(DEPTH);
		end else begin
			cfg.ring_size = cap_q;
		end
	end

endmodule

[hdl/byte_ring_fifo_overwrite_top.sv]
// Channel  Direction  Handshake           Payload
// in       sink       in_valid/in_ready   req_type, byte_in, burst_len, burst_first
// out      source     out_valid/out_ready status, byte_out, last, fill_level,
//                                         overwritten_flag, overwrite_event
// cfg      APB slave  psel/penable/pready paddr, pwdata, prdata
//
// Enqueue byte: result (if any) lands in the output register.
// Dequeue of N bytes: no new request is accepted until the last read byte has moved out;
//   one RAM read per cycle unless the output stalls; the store's single read port sets the pace.
// Reset: pointers, fill, sticky flag and burst state cleared; store left as is.
// Output stalls back up the read pipeline; input is held off during a dequeue.
module byte_ring_fifo_overwrite_top
	import brfo_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	// request channel
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	input  logic [BYTE_W-1:0] byte_in,
	input  logic [LEN_W-1:0]  burst_len,
	input  logic              burst_first,
	// result channel
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [BYTE_W-1:0] byte_out,
	output logic              last,
	output logic [LEN_W-1:0]  fill_level,
	output logic              overwritten_flag,
	output logic              overwrite_event
);

	localparam int AW = $clog2(DEPTH);

	cfg_t cfg;

	brfo_cfg #(
		.DEPTH(DEPTH)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// ring increment, wrapping at the ring size in use
	function automatic logic [AW-1:0] adv(input logic [AW-1:0] idx,
		input logic [LEN_W-1:0] cap);
		logic [LEN_W-1:0] n;
		n = LEN_W'(idx) + LEN_W'(1);
		adv = (n >= cap) ? '0 : n[AW-1:0];
	endfunction

	// ring state
	logic [AW-1:0]    wr_idx_q, wr_idx_d;
	logic [AW-1:0]    rd_idx_q, rd_idx_d;
	logic [LEN_W-1:0] fill_q, fill_d;
	logic             sticky_q, sticky_d;
	// open enqueue burst
	logic [LEN_W-1:0] rem_q, rem_d;
	logic             drop_q, drop_d;
	logic             ovw_q, ovw_d;
	// dequeue sequencer
	fsm_t             state_q, state_d;
	logic [LEN_W-1:0] deq_cnt_q;
	logic             pend_q;       // RAM read data waiting to move out
	logic             pend_last_q;
	// output register
	logic             out_valid_q;
	status_t          status_q;
	logic [BYTE_W-1:0] byte_q;
	logic             last_q;
	logic [LEN_W-1:0] fill_out_q;
	logic             flag_q;
	logic             event_q;

	logic             acc;
	logic             out_free;
	logic             consume;
	logic             rd_issue;
	logic             deq_start;
	logic             mem_we;
	logic             res_load;
	status_t          res_status;
	logic             res_event;
	logic [LEN_W-1:0] cap;
	logic [LEN_W-1:0] blen;
	logic [LEN_W-1:0] space;
	logic [BYTE_W-1:0] rd_data;

	assign cap      = cfg.ring_size;
	assign blen     = (burst_len == '0) ? LEN_W'(1) : burst_len;
	assign space    = cap - fill_q;
	assign out_free = !out_valid_q || out_ready;
	assign consume  = pend_q && out_free;
	assign acc      = in_valid && in_ready;

	brfo_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(wr_idx_q),
		.wdata(byte_in),
		.re   (rd_issue),
		.raddr(rd_idx_q),
		.rdata(rd_data)
	);

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: if (deq_start) state_d = FSM_DEQ;
			FSM_DEQ:  if (rd_issue && deq_cnt_q == LEN_W'(1)) state_d = FSM_IDLE;
			default:  state_d = FSM_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		in_ready = 1'b0;
		rd_issue = 1'b0;
		unique case (state_q)
			FSM_IDLE: in_ready = !pend_q && out_free;
			FSM_DEQ:  rd_issue = !pend_q || consume;
			default:  ;
		endcase
	end

	// request decode and ring update
	always_comb begin
		logic [LEN_W-1:0] rem_e;
		logic             ovw_e;
		logic             do_wr;

		wr_idx_d   = wr_idx_q;
		rd_idx_d   = rd_idx_q;
		fill_d     = fill_q;
		sticky_d   = sticky_q;
		rem_d      = rem_q;
		drop_d     = drop_q;
		ovw_d      = ovw_q;
		rem_e      = rem_q;
		ovw_e      = ovw_q;
		do_wr      = 1'b0;
		mem_we     = 1'b0;
		res_load   = 1'b0;
		res_status = ST_OK;
		res_event  = 1'b0;
		deq_start  = 1'b0;

		if (acc) begin
			if (req_type == REQ_DEQ) begin
				res_load = 1'b1;
				if (burst_len == '0) begin
					res_status = ST_NO_DATA;
				end else if (burst_len > cap) begin
					res_status = ST_TOO_LONG;
				end else if (burst_len > fill_q) begin
					res_status = ST_NO_DATA;
				end else begin
					// results report the level after the whole request
					res_load  = 1'b0;
					deq_start = 1'b1;
					fill_d    = fill_q - burst_len;
					sticky_d  = 1'b0;
				end
			end else if (burst_first) begin
				ovw_e = 1'b0;
				if (blen > cap || (blen > space && !cfg.ow_en)) begin
					// reject; rest of the burst is swallowed
					res_load   = 1'b1;
					res_status = (blen > cap) ? ST_TOO_LONG : ST_NO_SPACE;
					rem_d      = blen - LEN_W'(1);
					drop_d     = (blen != LEN_W'(1));
					ovw_d      = 1'b0;
				end else begin
					rem_e = blen;
					do_wr = 1'b1;
				end
			end else if (rem_q != '0) begin
				if (drop_q) begin
					rem_d  = rem_q - LEN_W'(1);
					drop_d = (rem_q != LEN_W'(1));
				end else begin
					do_wr = 1'b1;
				end
			end
			// stray continuation byte: no change, no result
		end

		if (do_wr) begin
			drop_d   = 1'b0;
			mem_we   = 1'b1;
			res_load = 1'b1;
			if (fill_q >= cap) begin
				// full: drop the oldest byte
				rd_idx_d = adv(rd_idx_q, cap);
				sticky_d = 1'b1;
				ovw_e    = 1'b1;
			end else begin
				fill_d = fill_q + LEN_W'(1);
			end
			wr_idx_d = adv(wr_idx_q, cap);
			rem_d    = rem_e - LEN_W'(1);
			if (rem_e == LEN_W'(1)) begin
				res_event = ovw_e;
				ovw_d     = 1'b0;
			end else begin
				ovw_d = ovw_e;
			end
		end

		if (rd_issue) begin
			rd_idx_d = adv(rd_idx_q, cap);
		end

		// capacity write empties the ring, sticky flag survives
		if (cfg.flush) begin
			wr_idx_d = '0;
			rd_idx_d = '0;
			fill_d   = '0;
			rem_d    = '0;
			drop_d   = 1'b0;
			ovw_d    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q    <= '0;
			rd_idx_q    <= '0;
			fill_q      <= '0;
			sticky_q    <= 1'b0;
			rem_q       <= '0;
			drop_q      <= 1'b0;
			ovw_q       <= 1'b0;
			state_q     <= FSM_IDLE;
			deq_cnt_q   <= '0;
			pend_q      <= 1'b0;
			pend_last_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			wr_idx_q <= wr_idx_d;
			rd_idx_q <= rd_idx_d;
			fill_q   <= fill_d;
			sticky_q <= sticky_d;
			rem_q    <= rem_d;
			drop_q   <= drop_d;
			ovw_q    <= ovw_d;
			state_q  <= state_d;

			if (deq_start) begin
				deq_cnt_q <= burst_len;
			end else if (rd_issue) begin
				deq_cnt_q <= deq_cnt_q - LEN_W'(1);
			end

			if (rd_issue) begin
				pend_q      <= 1'b1;
				pend_last_q <= (deq_cnt_q == LEN_W'(1));
			end else if (consume) begin
				pend_q <= 1'b0;
			end

			if (res_load || consume) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (res_load) begin
			status_q   <= res_status;
			byte_q     <= '0;
			last_q     <= 1'b1;
			fill_out_q <= fill_d;
			flag_q     <= sticky_d;
			event_q    <= res_event;
		end else if (consume) begin
			status_q   <= ST_OK;
			byte_q     <= rd_data;
			last_q     <= pend_last_q;
			fill_out_q <= fill_q;
			flag_q     <= sticky_q;
			event_q    <= 1'b0;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign byte_out         = byte_q;
	assign last             = last_q;
	assign fill_level       = fill_out_q;
	assign overwritten_flag = flag_q;
	assign overwrite_event  = event_q;

`ifndef ASSERT_OFF
	// ring never holds more than its size
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= cap)
		else $error("fill exceeds ring size");

	// dequeue sequencer never sits in its loop with nothing left to read
	a_deq_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_DEQ |-> deq_cnt_q != '0)
		else $error("dequeue active with zero count");

	// read data awaiting a blocked output is not dropped
	a_pend_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q && out_valid_q && !out_ready) |=> pend_q && $stable(rd_data))
		else $error("pending read data lost");
`endif

endmodule
